@@ src/mst_pkg.sv @@
// Shared types and constants for the multi-slot one-shot timer.
package mst_pkg;

    localparam int CNT_W             = 16;
    localparam int PRESC_W           = 6;
    localparam int DIV_W             = 7;
    localparam int SLOT_W            = 3;
    localparam int TICKS_W           = 16;
    localparam int EXP_W             = 4;
    localparam int DEFAULT_NUM_SLOTS = 5;

    localparam logic [DIV_W-1:0] DIV_MAX   = DIV_W'(64);
    localparam logic [DIV_W-1:0] DIV_MIN   = DIV_W'(1);
    localparam logic [DIV_W-1:0] DIV_RESET = DIV_W'(32);

    // Item action codes.
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_REG   = 2'd1,
        ACT_UNREG = 2'd2,
        ACT_NOP   = 2'd3
    } t_action;

    // Per-slot control from the top level for one accepted item.
    typedef struct packed {
        logic load;
        logic clear;
        logic advance;
        logic one_shot;
    } t_slot_ctrl;

endpackage

@@ src/mst_ifs.sv @@
// Valid/ready channel interfaces for timer items and timer results.
interface mst_in_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 action;
    logic [mst_pkg::SLOT_W-1:0] slot;
    logic [mst_pkg::TICKS_W-1:0] ticks;
    logic                       has_handler;

    modport source (output valid, action, slot, ticks, has_handler, input ready);
    modport sink   (input valid, action, slot, ticks, has_handler, output ready);
endinterface

interface mst_out_if;
    logic                      valid;
    logic                      ready;
    logic [mst_pkg::EXP_W-1:0] expired_slots;
    logic                      tick_slot_match;
    logic [mst_pkg::CNT_W-1:0] count_value;
    logic                      counting;

    modport source (output valid, expired_slots, tick_slot_match, count_value, counting,
                    input ready);
    modport sink   (input valid, expired_slots, tick_slot_match, count_value, counting,
                    output ready);
endinterface

@@ src/mst_slot.sv @@
// One compare slot: compare value, armed flag and match detection.
module mst_slot (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mst_pkg::t_slot_ctrl       i_ctrl,
    input  logic [mst_pkg::CNT_W-1:0] i_load_value,
    input  logic [mst_pkg::CNT_W-1:0] i_new_count,
    output logic                      o_armed,
    output logic                      o_armed_next,
    output logic                      o_match
);
    import mst_pkg::*;

    logic [CNT_W-1:0] r_cmp;
    logic [CNT_W-1:0] n_cmp;
    logic             r_armed;
    logic             n_armed;

    // A match needs an armed slot and a counter step onto its compare value.
    assign o_match = r_armed & i_ctrl.advance & (r_cmp == i_new_count);

    // Arming takes priority; a one-shot slot disarms itself when it fires.
    always_comb begin
        n_cmp   = r_cmp;
        n_armed = r_armed;
        if (i_ctrl.load) begin
            n_cmp   = i_load_value;
            n_armed = 1'b1;
        end else if (i_ctrl.clear) begin
            n_armed = 1'b0;
        end else if (o_match && i_ctrl.one_shot) begin
            n_armed = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
        end else begin
            r_armed <= n_armed;
        end
    end

    // The compare value is only read while armed, so it needs no reset.
    always_ff @(posedge i_clk) begin
        r_cmp <= n_cmp;
    end

    assign o_armed      = r_armed;
    assign o_armed_next = n_armed;

endmodule

@@ src/multi_slot_oneshot_timer.sv @@
// Top level of the multi-slot one-shot timer: counter, prescaler, slots, result register.
//
//  Channel  Dir  Handshake             Payload
//  i_in     in   valid/ready           action, slot, ticks, has_handler
//  o_out    out  valid/ready           expired_slots, tick_slot_match, count_value, counting
//  i_cfg    in   write enable, no wait divide_by (7 bits)
//
// Each item is processed in the cycle of its transfer and its result appears in the
// output register on the next cycle; one item per cycle is sustained while o_out is ready.
// i_in.ready is high when the result register is empty or is being taken this cycle.
// A stall on o_out holds the result and blocks further input transfers.
// Synchronous reset clears the counter, the prescaler and all armed flags.
module multi_slot_oneshot_timer #(
    parameter int NUM_SLOTS = mst_pkg::DEFAULT_NUM_SLOTS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [mst_pkg::DIV_W-1:0] i_cfg_wdata,
    mst_in_if.sink                    i_in,
    mst_out_if.source                 o_out
);
    import mst_pkg::*;

    logic [DIV_W-1:0]   r_divide_by;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [PRESC_W-1:0] r_presc;
    logic [PRESC_W-1:0] n_presc;

    logic               r_out_valid;
    logic [EXP_W-1:0]   r_out_exp;
    logic               r_out_match0;
    logic [CNT_W-1:0]   r_out_count;
    logic               r_out_counting;

    logic               w_xfer;
    logic               w_is_tick;
    logic               w_is_reg;
    logic               w_is_unreg;
    logic               w_advance;
    logic [DIV_W-1:0]   w_div;
    logic [CNT_W-1:0]   w_ticks_eff;
    logic [CNT_W-1:0]   w_load_value;
    logic [EXP_W-1:0]   w_expired;
    logic [EXP_W-1:0]   w_exp_armed;

    logic [NUM_SLOTS-1:0] w_armed;
    logic [NUM_SLOTS-1:0] w_armed_next;
    logic [NUM_SLOTS-1:0] w_match;

    // Input transfer when the result register can take a new result.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_xfer     = i_in.valid && i_in.ready;
    assign w_is_tick  = (i_in.action == ACT_TICK);
    assign w_is_reg   = (i_in.action == ACT_REG);
    assign w_is_unreg = (i_in.action == ACT_UNREG);

    // Divider register; zero behaves as one and large values saturate.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divide_by <= DIV_RESET;
        end else if (i_cfg_we) begin
            r_divide_by <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (r_divide_by == '0) begin
            w_div = DIV_MIN;
        end else if (r_divide_by > DIV_MAX) begin
            w_div = DIV_MAX;
        end else begin
            w_div = r_divide_by;
        end
    end

    // Prescaler and counter; they only run on accepted tick items while some slot is armed.
    always_comb begin
        n_count   = r_count;
        n_presc   = r_presc;
        w_advance = 1'b0;
        if (w_xfer && w_is_tick && (|w_armed)) begin
            if (({1'b0, r_presc} + DIV_W'(1)) >= w_div) begin
                n_presc   = '0;
                n_count   = r_count + CNT_W'(1);
                w_advance = 1'b1;
            end else begin
                n_presc = r_presc + PRESC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_presc <= '0;
        end else begin
            r_count <= n_count;
            r_presc <= n_presc;
        end
    end

    // New compare value: a zero delay counts as one, the sum wraps.
    assign w_ticks_eff  = (i_in.ticks == '0) ? CNT_W'(1) : i_in.ticks;
    assign w_load_value = r_count + w_ticks_eff;

    // Compare slots; slot 0 is periodic and the rest need a handler to arm.
    for (genvar gi = 0; gi < NUM_SLOTS; gi++) begin : g_slot
        t_slot_ctrl w_ctrl;
        logic       w_sel;

        assign w_sel           = (i_in.slot == SLOT_W'(gi));
        assign w_ctrl.load     = w_xfer && w_is_reg && w_sel
                                 && ((gi == 0) || i_in.has_handler);
        assign w_ctrl.clear    = w_xfer && w_is_unreg && w_sel;
        assign w_ctrl.advance  = w_advance;
        assign w_ctrl.one_shot = (gi != 0);

        mst_slot u_slot (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_load_value (w_load_value),
            .i_new_count  (n_count),
            .o_armed      (w_armed[gi]),
            .o_armed_next (w_armed_next[gi]),
            .o_match      (w_match[gi])
        );
    end

    // Expired bits for slots 1 to 4, where they exist.
    for (genvar gk = 0; gk < EXP_W; gk++) begin : g_exp
        if (gk + 1 < NUM_SLOTS) begin : g_on
            assign w_expired[gk]   = w_match[gk+1];
            assign w_exp_armed[gk] = w_armed[gk+1];
        end else begin : g_off
            assign w_expired[gk]   = 1'b0;
            assign w_exp_armed[gk] = 1'b0;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_xfer) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_xfer) begin
            r_out_exp      <= w_expired;
            r_out_match0   <= w_match[0];
            r_out_count    <= n_count;
            r_out_counting <= |w_armed_next;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.expired_slots   = r_out_exp;
    assign o_out.tick_slot_match = r_out_match0;
    assign o_out.count_value     = r_out_count;
    assign o_out.counting        = r_out_counting;

    // The counter holds while no slot is armed.
    a_count_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(|w_armed) |=> $stable(r_count))
        else $error("counter moved with no slot armed");

    // A pending result reflects the live running state.
    a_counting_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_counting == (|w_armed)) && (r_out_count == r_count))
        else $error("pending result disagrees with timer state");

    // A slot reported as expired is no longer armed.
    a_expired_disarmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_exp & w_exp_armed) == '0))
        else $error("expired slot still armed");

    // The periodic slot stays armed after a match.
    a_slot0_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_match0) |-> w_armed[0])
        else $error("periodic slot disarmed on match");

endmodule

@@ verif/multi_slot_oneshot_timer_tb.sv @@
// Self-checking testbench for the multi-slot one-shot timer with a cycle-level result predictor.
module multi_slot_oneshot_timer_tb;
    import mst_pkg::*;

    localparam int SLOTS          = DEFAULT_NUM_SLOTS;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 80;

    typedef struct packed {
        t_action             action;
        logic [SLOT_W-1:0]   slot;
        logic [TICKS_W-1:0]  ticks;
        logic                has_handler;
    } t_timer_req;

    typedef struct packed {
        logic [EXP_W-1:0]    expired_slots;
        logic                tick_slot_match;
        logic [CNT_W-1:0]    count_value;
        logic                counting;
    } t_timer_result;

    bit                clk;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [DIV_W-1:0]  cfg_wdata = '0;

    mst_in_if  in_ch ();
    mst_out_if out_ch ();

    multi_slot_oneshot_timer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // Requests waiting to be driven and results waiting to be seen.
    t_timer_req    request_queue[$];
    t_timer_result timer_results_due[$];

    // Predictor state.
    logic [CNT_W-1:0]   cnt_q;
    logic [PRESC_W-1:0] presc_q;
    logic [CNT_W-1:0]   match_at_q [SLOTS];
    logic [SLOTS-1:0]   armed_q;
    logic [DIV_W-1:0]   divider_q;

    int unsigned requests_sent;
    int unsigned requests_taken;
    int unsigned results_seen;
    int unsigned expiry_count;
    int unsigned periodic_hits;
    int unsigned divider_writes;
    int unsigned error_count;
    int unsigned idle_cycles;
    bit          in_took;

    // Clock with a period of four units.
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Apply one accepted request to the predicted timer state and return its result.
    function automatic t_timer_result predict_timer_result(t_timer_req req);
        t_timer_result res;
        int unsigned   eff_div;
        logic [CNT_W-1:0] span;
        res = '0;
        case (req.action)
            ACT_TICK: begin
                if (armed_q != '0) begin
                    eff_div = (divider_q == '0) ? 1 :
                              (divider_q > DIV_MAX) ? int'(DIV_MAX) : int'(divider_q);
                    if (int'(presc_q) + 1 >= eff_div) begin
                        presc_q = '0;
                        cnt_q   = cnt_q + 1'b1;
                        for (int s = 0; s < SLOTS; s++) begin
                            if (armed_q[s] && match_at_q[s] == cnt_q) begin
                                if (s == 0) begin
                                    res.tick_slot_match = 1'b1;
                                end else begin
                                    // One-shot slots disarm themselves when they fire.
                                    armed_q[s] = 1'b0;
                                    if (s <= EXP_W) res.expired_slots[s-1] = 1'b1;
                                end
                            end
                        end
                    end else begin
                        presc_q = presc_q + 1'b1;
                    end
                end
            end
            ACT_REG: begin
                if (req.slot < SLOTS && (req.slot == '0 || req.has_handler)) begin
                    span = (req.ticks == '0) ? CNT_W'(1) : req.ticks;
                    match_at_q[req.slot] = cnt_q + span;
                    armed_q[req.slot]    = 1'b1;
                end
            end
            ACT_UNREG: begin
                if (req.slot < SLOTS) armed_q[req.slot] = 1'b0;
            end
            default: begin
            end
        endcase
        res.count_value = cnt_q;
        res.counting    = |armed_q;
        return res;
    endfunction

    // Check results, track configuration writes and predict accepted requests.
    always @(posedge clk) begin : result_check
        t_timer_req    taken;
        t_timer_result want;
        if (!rst_n) begin
            cnt_q     = '0;
            presc_q   = '0;
            armed_q   = '0;
            divider_q = DIV_RESET;
            for (int s = 0; s < SLOTS; s++) match_at_q[s] = '0;
            in_took   = 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (timer_results_due.size() == 0) begin
                    $error("result transfer with no request outstanding: count_value %h",
                           out_ch.count_value);
                    error_count++;
                end else begin
                    want = timer_results_due.pop_front();
                    expiry_count  += $countones(out_ch.expired_slots);
                    periodic_hits += out_ch.tick_slot_match;
                    if (out_ch.expired_slots !== want.expired_slots) begin
                        $error("expired_slots: expected %h, got %h",
                               want.expired_slots, out_ch.expired_slots);
                        error_count++;
                    end
                    if (out_ch.tick_slot_match !== want.tick_slot_match) begin
                        $error("tick_slot_match: expected %b, got %b",
                               want.tick_slot_match, out_ch.tick_slot_match);
                        error_count++;
                    end
                    if (out_ch.count_value !== want.count_value) begin
                        $error("count_value: expected %h, got %h",
                               want.count_value, out_ch.count_value);
                        error_count++;
                    end
                    if (out_ch.counting !== want.counting) begin
                        $error("counting: expected %b, got %b",
                               want.counting, out_ch.counting);
                        error_count++;
                    end
                end
            end
            if (cfg_we) begin
                divider_q = cfg_wdata;
                divider_writes++;
            end
            in_took = in_ch.valid && in_ch.ready;
            if (in_took) begin
                taken.action      = t_action'(in_ch.action);
                taken.slot        = in_ch.slot;
                taken.ticks       = in_ch.ticks;
                taken.has_handler = in_ch.has_handler;
                requests_taken++;
                timer_results_due.push_back(predict_timer_result(taken));
            end
        end
    end

    // Request driver: bursts of random length separated by random gaps.
    always @(negedge clk) begin : driver
        t_timer_req  next_req;
        int unsigned burst_left;
        int unsigned gap_left;
        if (!rst_n) begin
            in_ch.valid       <= 1'b0;
            in_ch.action      <= '0;
            in_ch.slot        <= '0;
            in_ch.ticks       <= '0;
            in_ch.has_handler <= 1'b0;
        end else if (!in_ch.valid || in_took) begin
            if (gap_left > 0) begin
                in_ch.valid <= 1'b0;
                gap_left--;
            end else if (request_queue.size() > 0) begin
                next_req = request_queue.pop_front();
                in_ch.action      <= next_req.action;
                in_ch.slot        <= next_req.slot;
                in_ch.ticks       <= next_req.ticks;
                in_ch.has_handler <= next_req.has_handler;
                in_ch.valid       <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver: a randomly chosen stall pattern, plus long holds.
    always @(negedge clk) begin : receiver
        int unsigned ready_mode;
        int unsigned mode_cycles;
        int unsigned rx_cycle;
        int unsigned hold_left;
        int unsigned holds_done;
        rx_cycle++;
        if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left--;
        end else if (holds_done < 2 && results_seen >= 300 * (holds_done + 1) &&
                     request_queue.size() > 40) begin
            // Hold off long enough for the result register to fill and block input.
            out_ch.ready <= 1'b0;
            hold_left = HOLD_CYCLES;
            holds_done++;
        end else begin
            mode_cycles++;
            if (mode_cycles == 50) begin
                mode_cycles = 0;
                ready_mode  = $urandom_range(0, 3);
            end
            case (ready_mode)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= 1'($urandom_range(0, 1));
                2:       out_ch.ready <= (rx_cycle % 3 == 0);
                default: out_ch.ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // End the run when no transfer of any kind has happened for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout after %0d cycles without a transfer", idle_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic offer(t_action act, logic [SLOT_W-1:0] slot, logic [TICKS_W-1:0] ticks,
                         logic handler);
        t_timer_req req;
        req.action      = act;
        req.slot        = slot;
        req.ticks       = ticks;
        req.has_handler = handler;
        request_queue.push_back(req);
        requests_sent++;
    endtask

    // Wait until every request has been taken and every result has come back.
    task automatic wait_drained();
        while (request_queue.size() != 0 || requests_taken != requests_sent ||
               timer_results_due.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_divider(logic [DIV_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    initial begin : stimulus
        int unsigned divider_plan[12];
        int unsigned eff_div;
        int unsigned run_len;
        int unsigned budget;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // At the reset divider the prescaler counts but the counter does not yet move;
        // stopping keeps the partial prescale.
        offer(ACT_REG,   3'd0, 16'd3,      1'b0);
        offer(ACT_TICK,  3'd0, 16'd0,      1'b0);
        offer(ACT_TICK,  3'd7, 16'hFFFF,   1'b1);
        offer(ACT_UNREG, 3'd0, 16'd0,      1'b0);
        offer(ACT_TICK,  3'd0, 16'd0,      1'b0);
        wait_drained();
        write_divider(DIV_MIN);

        // Missing handler, zero delay, simultaneous expiry, wrapping compare and re-arm.
        offer(ACT_REG,   3'd1, 16'd5,      1'b0);
        offer(ACT_TICK,  3'd0, 16'd0,      1'b0);
        offer(ACT_REG,   3'd0, 16'd0,      1'b1);
        offer(ACT_TICK,  3'd0, 16'd0,      1'b0);
        offer(ACT_REG,   3'd1, 16'd2,      1'b1);
        offer(ACT_REG,   3'd2, 16'd2,      1'b1);
        offer(ACT_REG,   3'd3, 16'hFFFF,   1'b1);
        offer(ACT_REG,   3'd4, 16'd9,      1'b1);
        offer(ACT_REG,   3'd4, 16'd1,      1'b1);
        offer(ACT_TICK,  3'd0, 16'd0,      1'b0);
        offer(ACT_TICK,  3'd0, 16'd0,      1'b0);
        // Out-of-range slots, a no-op and unregistering down to an idle counter.
        offer(ACT_REG,   3'd7, 16'd1,      1'b1);
        offer(ACT_UNREG, 3'd5, 16'd0,      1'b1);
        offer(ACT_NOP,   3'd2, 16'h5A5A,   1'b1);
        offer(ACT_UNREG, 3'd2, 16'd0,      1'b0);
        offer(ACT_UNREG, 3'd3, 16'd0,      1'b0);
        offer(ACT_UNREG, 3'd0, 16'd0,      1'b0);
        offer(ACT_TICK,  3'd0, 16'd0,      1'b0);
        offer(ACT_REG,   3'd3, 16'd1,      1'b1);
        offer(ACT_TICK,  3'd0, 16'd0,      1'b0);

        // Random phases, each at its own divider setting, including zero and saturation.
        divider_plan = '{0, 2, 64, 1, 127, 3, 65, 32, 5, 1, 0, 2};
        divider_plan[10] = $urandom_range(1, 127);
        foreach (divider_plan[p]) begin
            wait_drained();
            write_divider(DIV_W'(divider_plan[p]));
            eff_div = (divider_plan[p] == 0) ? 1 :
                      (divider_plan[p] > 64) ? 64 : divider_plan[p];
            budget = requests_sent + 90;
            while (requests_sent < budget) begin
                if ($urandom_range(0, 9) < 7) begin
                    // Arm a few slots, mostly with short delays, then offer a run of tick items.
                    repeat ($urandom_range(1, 3))
                        offer(ACT_REG, SLOT_W'($urandom_range(0, SLOTS - 1)),
                              TICKS_W'(($urandom_range(0, 9) == 0) ? $urandom :
                                       $urandom_range(0, 6)),
                              1'b1);
                    run_len = $urandom_range(1, 8 * eff_div);
                    if (run_len > 40) run_len = 40;
                    repeat (run_len)
                        offer(ACT_TICK, SLOT_W'($urandom_range(0, 7)), TICKS_W'($urandom),
                              1'($urandom_range(0, 1)));
                    if ($urandom_range(0, 2) == 0)
                        offer(ACT_UNREG, SLOT_W'($urandom_range(0, SLOTS - 1)),
                              TICKS_W'($urandom), 1'($urandom_range(0, 1)));
                end else begin
                    offer(t_action'($urandom_range(0, 3)), SLOT_W'($urandom_range(0, 7)),
                          TICKS_W'($urandom), 1'($urandom_range(0, 1)));
                end
            end
        end

        wait_drained();
        repeat (4) @(negedge clk);
        $display("Covered %0d requests and %0d results across %0d divider settings.",
                 requests_taken, results_seen, divider_writes + 1);
        $display("Observed %0d one-shot expiries and %0d periodic slot matches.",
                 expiry_count, periodic_hits);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/mst_pkg.sv
src/mst_ifs.sv
src/mst_slot.sv
src/multi_slot_oneshot_timer.sv
verif/multi_slot_oneshot_timer_tb.sv
